@@ hdl/assert_macros.svh @@
// Assertion macros for the timestep barrier event injector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked on every edge outside of reset.
`define TBEI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every edge, reset included.
`define TBEI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBEI_ASSERT(lbl, clk, rst_n, prop, msg)
`define TBEI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/tbei_pkg.sv @@
// Shared constants and types for the timestep barrier event injector.
package tbei_pkg;
	localparam int unsigned STORE_DEPTH = 1024;
	localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
	localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int unsigned WORD_W = 32;
	localparam int unsigned TS_W = 31;
	localparam int unsigned BAR_W = 6;
	localparam int unsigned NR_W = 7;
	localparam int unsigned STAMP_BIT = 31;

	localparam logic [WORD_W-1:0] BARRIER_WORD = '1;
	localparam logic [NR_W-1:0] NUM_ROUTERS_RST = NR_W'(2);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_BUS = 1'b1;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  wr_en;
		cnt_t  wr_idx;
		word_t wr_data;
		logic  adv;
		cnt_t  rd_idx;
		cnt_t  rd_idx_nx;
	} store_ctrl_t;
endpackage

@@ hdl/tbei_store.sv @@
// Event store memory with a two-word read window kept at the read index.
module tbei_store (
	input  logic                clk,
	input  tbei_pkg::store_ctrl_t ctrl,
	output tbei_pkg::word_t     head0,
	output tbei_pkg::word_t     head1,
	output tbei_pkg::word_t     head0_nx
);
	import tbei_pkg::*;

	word_t          mem_q [STORE_DEPTH];
	word_t          rd_s1;
	logic           fwd_hit_s1;
	word_t          fwd_data_s1;
	word_t          head0_q;
	word_t          head1_q;
	word_t          head1_nx;
	word_t          rd_word;
	logic [CNT_W:0] rd_addr;
	logic [CNT_W:0] wr_addr_x;
	logic [CNT_W:0] rd_idx_x;
	logic           hit0;
	logic           hit1;

	assign wr_addr_x = {1'b0, ctrl.wr_idx};
	assign rd_idx_x = {1'b0, ctrl.rd_idx};
	// Prefetch the word two past the read index that the next cycle will see.
	assign rd_addr = {1'b0, ctrl.rd_idx_nx} + (CNT_W + 1)'(2);
	assign rd_word = fwd_hit_s1 ? fwd_data_s1 : rd_s1;
	assign hit0 = ctrl.wr_en && (wr_addr_x == rd_idx_x);
	assign hit1 = ctrl.wr_en && (wr_addr_x == rd_idx_x + (CNT_W + 1)'(1));

	always_comb begin
		head0_nx = head0_q;
		head1_nx = head1_q;
		if (ctrl.adv) begin
			head0_nx = head1_q;
			head1_nx = rd_word;
		end else begin
			if (hit0) begin
				head0_nx = ctrl.wr_data;
			end
			if (hit1) begin
				head1_nx = ctrl.wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[ctrl.wr_idx[ADDR_W-1:0]] <= ctrl.wr_data;
		end
		rd_s1 <= mem_q[rd_addr[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		// Cover a write that lands on the address being read this cycle.
		fwd_hit_s1 <= ctrl.wr_en && (wr_addr_x == rd_addr);
		fwd_data_s1 <= ctrl.wr_data;
		head0_q <= head0_nx;
		head1_q <= head1_nx;
	end

	assign head0 = head0_q;
	assign head1 = head1_q;
endmodule

@@ hdl/timestep_barrier_event_injector.sv @@
// Top level of the timestep barrier event injector.
//
// Input channel (in_valid / in_stall): opcode OP_LOAD appends load_word to the
// event store (ignored once full); OP_BUS reports one bus cycle: rx_valid and
// rx_word for the received word, sent_ok for a grant of the word we offered.
// Output channel (out_valid / out_stall): one result per request, giving the
// word to offer in the next bus cycle and the done flags.
// Configuration: cfg_we writes num_routers from cfg_wdata; the user must do so
// only while idle, as the block does not enforce it. One request is taken every
// clock unless the output stalls. The event store is a single-port-write,
// single-port-read memory with a registered read; a two-word window at the read
// index plus one prefetched word keep the store out of the per-request loop.
// A stalled result is held in the output register; the input stalls only
// while that register is full and the receiver stalls.
// Reset puts the block in the wait-for-barriers phase with an empty store,
// read index zero, barrier count zero and the timestep at all ones; no
// memory clearing pass is needed, so requests are taken right after reset.
module timestep_barrier_event_injector (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tbei_pkg::NR_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [31:0]                load_word,
	input  logic                       rx_valid,
	input  logic [31:0]                rx_word,
	input  logic                       sent_ok,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       send_valid,
	output logic [31:0]                send_word,
	output logic                       no_more_events,
	output logic                       more_events
);
	import tbei_pkg::*;

`include "assert_macros.svh"

	typedef enum logic [1:0] {
		PH_WAIT_OTHERS  = 2'd0,
		PH_WAIT_BARRIER = 2'd1,
		PH_WAIT_SPIKE   = 2'd2
	} phase_t;

	phase_t            phase_q, phase_nx;
	logic [NR_W-1:0]   num_routers_q;
	logic [BAR_W-1:0]  barriers_q, barriers_nx, barriers_inc;
	logic [TS_W-1:0]   ts_q, ts_nx, ts_inc;
	cnt_t              ri_q, ri_nx;
	cnt_t              count_q, count_nx;
	logic              out_valid_q;
	logic              send_valid_q, send_valid_nx;
	word_t             send_word_q, send_word_nx;
	logic              more_q, more_nx;
	logic              accept;
	logic              bar_hit;
	logic              head_match;
	logic              tail_end;
	store_ctrl_t       st_ctrl;
	word_t             head0, head1, head0_nx;

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	tbei_store u_store (
		.clk      (clk),
		.ctrl     (st_ctrl),
		.head0    (head0),
		.head1    (head1),
		.head0_nx (head0_nx)
	);

	always_comb begin
		bar_hit = rx_valid && (rx_word == BARRIER_WORD);
		barriers_inc = barriers_q + BAR_W'(bar_hit);
		ts_inc = ts_q + TS_W'(1);
		head_match = (ri_q < count_q) && head0[STAMP_BIT] && (head0[TS_W-1:0] == ts_inc);
		// End of the event run once no stored word follows head0 or head1 is a timestamp.
		tail_end = ({1'b0, ri_q} + (CNT_W + 1)'(1) >= {1'b0, count_q}) || head1[STAMP_BIT];

		phase_nx = phase_q;
		barriers_nx = barriers_q;
		ts_nx = ts_q;
		ri_nx = ri_q;
		count_nx = count_q;
		st_ctrl.wr_en = 1'b0;
		st_ctrl.wr_idx = count_q;
		st_ctrl.wr_data = load_word;
		st_ctrl.adv = 1'b0;

		if (accept) begin
			if (opcode == OP_LOAD) begin
				if (count_q < CNT_W'(STORE_DEPTH)) begin
					st_ctrl.wr_en = 1'b1;
					count_nx = count_q + CNT_W'(1);
				end
			end else begin
				barriers_nx = barriers_inc;
				case (phase_q)
					PH_WAIT_OTHERS: begin
						if ({1'b0, barriers_inc} == num_routers_q - NR_W'(1)) begin
							phase_nx = PH_WAIT_BARRIER;
						end
					end
					PH_WAIT_BARRIER: begin
						if (sent_ok) begin
							barriers_nx = '0;
							ts_nx = ts_inc;
							phase_nx = PH_WAIT_OTHERS;
							// Skip the matching timestamp and stream what follows.
							if (head_match) begin
								st_ctrl.adv = 1'b1;
								ri_nx = ri_q + CNT_W'(1);
								if (!tail_end) begin
									phase_nx = PH_WAIT_SPIKE;
								end
							end
						end
					end
					PH_WAIT_SPIKE: begin
						if (sent_ok) begin
							st_ctrl.adv = 1'b1;
							ri_nx = ri_q + CNT_W'(1);
							if (tail_end) begin
								phase_nx = PH_WAIT_OTHERS;
							end
						end
					end
					default: begin
						phase_nx = PH_WAIT_OTHERS;
					end
				endcase
			end
		end

		st_ctrl.rd_idx = ri_q;
		st_ctrl.rd_idx_nx = ri_nx;

		send_valid_nx = 1'b0;
		send_word_nx = '0;
		if (phase_nx == PH_WAIT_BARRIER) begin
			send_valid_nx = 1'b1;
			send_word_nx = BARRIER_WORD;
		end else if (phase_nx == PH_WAIT_SPIKE && ri_nx < count_nx) begin
			send_valid_nx = 1'b1;
			send_word_nx = head0_nx;
		end
		more_nx = (phase_nx == PH_WAIT_SPIKE) || (ri_nx < count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_OTHERS;
			num_routers_q <= NUM_ROUTERS_RST;
			barriers_q <= '0;
			ts_q <= '1;
			ri_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			send_valid_q <= 1'b0;
			send_word_q <= '0;
			more_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_routers_q <= cfg_wdata;
			end
			phase_q <= phase_nx;
			barriers_q <= barriers_nx;
			ts_q <= ts_nx;
			ri_q <= ri_nx;
			count_q <= count_nx;
			if (accept) begin
				out_valid_q <= 1'b1;
				send_valid_q <= send_valid_nx;
				send_word_q <= send_word_nx;
				more_q <= more_nx;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign send_valid = send_valid_q;
	assign send_word = send_word_q;
	assign more_events = more_q;
	assign no_more_events = !more_q;

	`TBEI_ASSERT(a_ri_in_range, clk, arst_n, ri_q <= count_q, "read index past event count")
	`TBEI_ASSERT(a_spike_has_event, clk, arst_n, (phase_q == PH_WAIT_SPIKE) |-> (ri_q < count_q), "sending events with store exhausted")
	`TBEI_ASSERT(a_load_keeps_ri, clk, arst_n, (accept && opcode == OP_LOAD) |=> $stable(ri_q), "load moved the read index")
	`TBEI_ASSERT(a_no_stamp_sent, clk, arst_n, (send_valid_q && send_word_q != BARRIER_WORD) |-> !send_word_q[STAMP_BIT], "timestamp offered as event")
	`TBEI_ASSERT(a_grant_clears, clk, arst_n, (accept && opcode == OP_BUS && phase_q == PH_WAIT_BARRIER && sent_ok) |=> (barriers_q == '0), "barrier count kept after grant")
endmodule

@@ bench/tbei_checker.sv @@
// Checker for the timestep barrier event injector: predicts each bus offer and compares results.
module tbei_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tbei_pkg::NR_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       opcode,
	input  tbei_pkg::word_t            load_word,
	input  logic                       rx_valid,
	input  tbei_pkg::word_t            rx_word,
	input  logic                       sent_ok,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       send_valid,
	input  tbei_pkg::word_t            send_word,
	input  logic                       no_more_events,
	input  logic                       more_events,
	output int                         mismatch_count,
	output int                         results_owed,
	output logic [tbei_pkg::TS_W-1:0]  ts_now,
	output tbei_pkg::cnt_t             unread_words
);
	import tbei_pkg::*;

	typedef enum logic [1:0] {PH_GATHER, PH_BARRIER, PH_SPIKES} inj_phase_t;

	typedef struct packed {
		logic  send_valid;
		word_t send_word;
		logic  no_more_events;
		logic  more_events;
	} bus_offer_t;

	word_t            spike_store [STORE_DEPTH];
	cnt_t             fill;
	cnt_t             rd;
	logic [TS_W-1:0]  ts;
	logic [BAR_W-1:0] bars;
	logic [NR_W-1:0]  routers;
	inj_phase_t       ph;
	bus_offer_t       offer_q [$];
	bus_offer_t       want;

	// Stream ends at the end of the store or at the next timestamp.
	function automatic logic stream_done();
		return rd >= fill || spike_store[rd[ADDR_W-1:0]][STAMP_BIT];
	endfunction

	function automatic bus_offer_t step_injector(logic op, word_t lw, logic rv, word_t rw,
			logic ok);
		bus_offer_t o;
		word_t head;
		if (op == OP_LOAD) begin
			if (fill < cnt_t'(STORE_DEPTH)) begin
				spike_store[fill[ADDR_W-1:0]] = lw;
				fill = fill + cnt_t'(1);
			end
		end else begin
			if (rv && rw == BARRIER_WORD)
				bars = bars + BAR_W'(1);
			case (ph)
				PH_GATHER: begin
					if ({1'b0, bars} == routers - NR_W'(1))
						ph = PH_BARRIER;
				end
				PH_BARRIER: begin
					if (ok) begin
						// drop any barrier counted in this same cycle
						bars = '0;
						ts = ts + TS_W'(1);
						ph = PH_GATHER;
						if (rd < fill) begin
							head = spike_store[rd[ADDR_W-1:0]];
							if (head[STAMP_BIT] && head[TS_W-1:0] == ts) begin
								rd = rd + cnt_t'(1);
								if (!stream_done())
									ph = PH_SPIKES;
							end
						end
					end
				end
				PH_SPIKES: begin
					if (ok) begin
						rd = rd + cnt_t'(1);
						if (stream_done())
							ph = PH_GATHER;
					end
				end
				default: ph = PH_GATHER;
			endcase
		end
		o.send_valid = 1'b0;
		o.send_word = '0;
		if (ph == PH_BARRIER) begin
			o.send_valid = 1'b1;
			o.send_word = BARRIER_WORD;
		end else if (ph == PH_SPIKES && rd < fill) begin
			o.send_valid = 1'b1;
			o.send_word = spike_store[rd[ADDR_W-1:0]];
		end
		o.more_events = (ph == PH_SPIKES) || (rd < fill);
		o.no_more_events = !o.more_events;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_GATHER;
			fill = '0;
			rd = '0;
			ts = '1;
			bars = '0;
			routers = NUM_ROUTERS_RST;
			offer_q.delete();
			mismatch_count = 0;
			results_owed = 0;
			ts_now = '1;
			unread_words = '0;
		end else begin
			if (cfg_we)
				routers = cfg_wdata;
			// compare before queuing, so a result never matches a request taken at the same edge
			if (out_valid && !out_stall) begin
				if (offer_q.size() == 0) begin
					$error("result with no request outstanding");
					mismatch_count++;
				end else begin
					want = offer_q.pop_front();
					if (send_valid !== want.send_valid) begin
						$error("send_valid: expected %0d, got %0d", want.send_valid, send_valid);
						mismatch_count++;
					end
					if (send_word !== want.send_word) begin
						$error("send_word: expected %h, got %h", want.send_word, send_word);
						mismatch_count++;
					end
					if (no_more_events !== want.no_more_events) begin
						$error("no_more_events: expected %0d, got %0d", want.no_more_events,
							no_more_events);
						mismatch_count++;
					end
					if (more_events !== want.more_events) begin
						$error("more_events: expected %0d, got %0d", want.more_events,
							more_events);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				offer_q.push_back(step_injector(opcode, load_word, rx_valid, rx_word, sent_ok));
			results_owed = offer_q.size();
			ts_now = ts;
			unread_words = fill - rd;
		end
	end
endmodule

@@ bench/testbench.sv @@
// Testbench top for the timestep barrier event injector: stimulus, flow control and verdict.
module testbench;
	import tbei_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic  op;
		word_t lw;
		logic  rv;
		word_t rw;
		logic  ok;
	} bus_req_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_we = 1'b0;
	logic [NR_W-1:0] cfg_wdata = '0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic            opcode = OP_BUS;
	word_t           load_word = '0;
	logic            rx_valid = 1'b0;
	word_t           rx_word = '0;
	logic            sent_ok = 1'b0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic            send_valid;
	word_t           send_word;
	logic            no_more_events;
	logic            more_events;

	int              mismatch_count;
	int              results_owed;
	logic [TS_W-1:0] ts_now;
	cnt_t            unread_words;

	bus_req_t        req_q [$];
	bus_req_t        next_req;
	int              burst_left = 1;
	int              gap_left = 0;
	int              stall_mode = 0;
	int              mode_left = 0;
	int              hold_asks = 0;
	int              hold_served = 0;
	int              hold_left = 0;
	int              idle_cycles = 0;

	timestep_barrier_event_injector DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.load_word      (load_word),
		.rx_valid       (rx_valid),
		.rx_word        (rx_word),
		.sent_ok        (sent_ok),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.send_valid     (send_valid),
		.send_word      (send_word),
		.no_more_events (no_more_events),
		.more_events    (more_events)
	);

	tbei_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.load_word      (load_word),
		.rx_valid       (rx_valid),
		.rx_word        (rx_word),
		.sent_ok        (sent_ok),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.send_valid     (send_valid),
		.send_word      (send_word),
		.no_more_events (no_more_events),
		.more_events    (more_events),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed),
		.ts_now         (ts_now),
		.unread_words   (unread_words)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Sender: present queued requests in bursts, hold the payload while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_q.size() != 0) begin
				next_req = req_q.pop_front();
				in_valid <= 1'b1;
				opcode <= next_req.op;
				load_word <= next_req.lw;
				rx_valid <= next_req.rv;
				rx_word <= next_req.rw;
				sent_ok <= next_req.ok;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
					gap_left = $urandom_range(0, 5);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall in random modes, and hold off for a long stretch on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_served != hold_asks) begin
				hold_served++;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic push_req(input logic op, input word_t lw, input logic rv, input word_t rw,
			input logic ok);
		while (req_q.size() >= 4)
			@(negedge clk);
		req_q.push_back({op, lw, rv, rw, ok});
	endtask

	task automatic push_load(input word_t w);
		push_req(OP_LOAD, w, 1'($urandom), $urandom, 1'($urandom));
	endtask

	task automatic push_bus(input logic rv, input word_t rw, input logic ok);
		push_req(OP_BUS, $urandom, rv, rw, ok);
	endtask

	task automatic offer_bus_cycle();
		push_bus($urandom_range(0, 9) < 7,
			($urandom_range(0, 3) != 0) ? BARRIER_WORD : word_t'($urandom),
			$urandom_range(0, 4) < 3);
	endtask

	// Wait until every request is taken and every result has come back.
	task automatic drain_injector();
		while (req_q.size() != 0 || in_valid || results_owed != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_routers(input logic [NR_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int              words_loaded;
		int              words;
		int              k;
		int              j;
		int              n_ev;
		int              n;
		int              bus_cap;
		logic [NR_W-1:0] routers_now;
		logic [TS_W-1:0] stamp_ts;
		logic [TS_W-1:0] next_stamp;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset router count of two, empty store, first timestep is zero.
		push_bus(1'b0, BARRIER_WORD, 1'b1);
		push_load({1'b1, 31'd0});
		push_load(32'h0000_0000);
		push_load(32'h7FFF_FFFF);
		push_load({1'b1, 31'd1});
		push_load({1'b1, 31'd3});
		push_load(32'h1234_5678);
		push_bus(1'b1, 32'h7FFF_FFFF, 1'b0);
		push_bus(1'b1, BARRIER_WORD, 1'b0);
		push_bus(1'b1, BARRIER_WORD, 1'b0);
		// grant together with a received barrier: that barrier is dropped
		push_bus(1'b1, BARRIER_WORD, 1'b1);
		push_bus(1'b0, 32'h0, 1'b0);
		push_bus(1'b0, 32'h0, 1'b1);
		push_load({1'b1, 31'd4});
		push_bus(1'b1, BARRIER_WORD, 1'b1);
		push_bus(1'b0, 32'h0, 1'b0);
		// timestep 1 is empty, timestep 2 has no stamp, timestep 3 streams one event
		push_bus(1'b0, 32'h0, 1'b1);
		push_bus(1'b1, BARRIER_WORD, 1'b0);
		push_bus(1'b0, 32'h0, 1'b1);
		push_bus(1'b1, BARRIER_WORD, 1'b0);
		push_bus(1'b0, 32'h0, 1'b1);
		push_bus(1'b0, 32'h0, 1'b1);
		push_bus(1'b1, BARRIER_WORD, 1'b0);
		push_bus(1'b0, 32'h0, 1'b1);
		words_loaded = 7;
		next_stamp = 31'd5;
		drain_injector();

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: routers_now = 7'd1;
				1: routers_now = 7'd3;
				2: routers_now = 7'd64;
				3: routers_now = 7'd0;
				4: routers_now = 7'd127;
				5: routers_now = 7'd2;
				default: routers_now = NR_W'($urandom_range(1, 8));
			endcase
			write_routers(routers_now);
			if (routers_now >= 7'd1 && routers_now <= 7'd8)
				words = $urandom_range(12, 36);
			else if (routers_now == 7'd64)
				words = 5;
			else
				words = 0;

			// Stamps must never fall behind the timestep, or the store jams for good.
			stamp_ts = (unread_words == 0) ? ts_now + TS_W'(1) : next_stamp;
			k = 0;
			while (k < words) begin
				push_load({1'b1, stamp_ts});
				k++;
				n_ev = $urandom_range(0, 4);
				for (j = 0; j < n_ev && k < words; j++) begin
					push_load({1'b0, 31'($urandom)});
					k++;
				end
				stamp_ts = stamp_ts + (($urandom_range(0, 3) == 0) ? 31'd2 : 31'd1);
			end
			words_loaded += words;
			next_stamp = stamp_ts;

			bus_cap = (routers_now == 7'd64) ? 140 : 30;
			if (p == 1)
				hold_asks++;
			n = 0;
			while (n < 10 || (unread_words != 0 && n < bus_cap)) begin
				offer_bus_cycle();
				n++;
			end
			drain_injector();
		end

		// Fill the store to the top: an event first, so no stamp sits at the boundary,
		// then random words and a few loads past full.
		write_routers(7'd2);
		push_load({1'b0, 31'($urandom)});
		words_loaded++;
		while (words_loaded < STORE_DEPTH + 4) begin
			if ($urandom_range(0, 15) == 0) begin
				offer_bus_cycle();
			end else begin
				push_load($urandom);
				words_loaded++;
			end
		end
		repeat (20) offer_bus_cycle();
		drain_injector();

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
